// ===== design/glyph_atlas_shelf_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator assertion macros
// Shared assertion forms for the checker attached to the allocator top level.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_UNIT_DEFINES_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define GASA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define GASA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define GASA_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gasa_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator package
// Beat types, result status codes and fixed constants of the allocator.
// ----------------------------------------------------------------------------
package gasa_pkg;

  localparam int GLYPH_PT_W = 10;
  localparam logic [GLYPH_PT_W-1:0] GLYPH_PT_RESET = 10'd16;
  localparam logic [GLYPH_PT_W-1:0] GLYPH_PT_MIN   = 10'd2;

  // A new page is 64 pixels wide per font point.
  localparam int PAGE_WIDTH_SHIFT = 6;

  // Division by five as a multiply and shift, exact for dividends below 2^15.
  localparam int DIV5_MUL_W = 16;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'd52429;
  localparam int DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_NEW_PAGE = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_NO_PAGES = 2'd3
  } status_t;

  typedef struct packed {
    logic [11:0] glyph_width;
    logic [11:0] glyph_height;
  } glyph_req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  page_index;
    logic [10:0] pos_x;
    logic [11:0] pos_y;
  } glyph_res_t;

endpackage

// ===== design/glyph_atlas_shelf_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator
// Shelf-packs glyph rectangles into atlas pages, one beat a cycle if unstalled.
// ----------------------------------------------------------------------------
// Each input beat carries one glyph's width and height; each output beat gives
// the placement status, the page index and the top-left corner of the glyph.
// The block takes a new beat in every cycle unless in_stall is high; the beat
// is held in the input register and its result in the result register. The
// placement itself is a single pass of compares and adds on the
// shelf cursor registers, so one item per cycle is sustained as long as the
// result side keeps taking beats. A stalled result holds the output register,
// and the input register still catches one more beat before in_stall rises.
// The font size register is written through cfg_we/cfg_wdata and should only
// change while no beat is in flight.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_allocator_unit #(
  parameter int MAX_PAGE_SIDE = 2048,
  parameter int MAX_PAGES     = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gasa_pkg::glyph_req_t            in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gasa_pkg::glyph_res_t            out_data,
  input  logic                            cfg_we,
  input  logic [gasa_pkg::GLYPH_PT_W-1:0] cfg_wdata
);

  logic                            in_vld_r;
  gasa_pkg::glyph_req_t            in_req_r;
  logic                            out_vld_r;
  gasa_pkg::glyph_res_t            out_res_r;
  logic [gasa_pkg::GLYPH_PT_W-1:0] glyph_pt_r;
  gasa_pkg::glyph_res_t            core_res;
  logic                            advance;

  // The held item moves on whenever the result register is empty or draining.
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_res_r;

  gasa_core #(
    .MAX_PAGE_SIDE (MAX_PAGE_SIDE),
    .MAX_PAGES     (MAX_PAGES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .req      (in_req_r),
    .glyph_pt (glyph_pt_r),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      glyph_pt_r <= gasa_pkg::GLYPH_PT_RESET;
    end else begin
      if (cfg_we) begin
        glyph_pt_r <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_data;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

endmodule

// ===== design/gasa_core.sv =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator core
// Holds the page and shelf cursor state and places one glyph per step.
// ----------------------------------------------------------------------------
module gasa_core #(
  parameter int MAX_PAGE_SIDE = 2048,
  parameter int MAX_PAGES     = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  gasa_pkg::glyph_req_t                req,
  input  logic [gasa_pkg::GLYPH_PT_W-1:0]     glyph_pt,
  output gasa_pkg::glyph_res_t                res
);

  localparam int SIDE_W = $clog2(MAX_PAGE_SIDE * 6 / 5 + 1);
  localparam int BASE_W = $clog2(MAX_PAGE_SIDE + 1);
  localparam int CW     = ((SIDE_W > 12) ? SIDE_W : 12) + 4;
  localparam int PC_W   = $clog2(MAX_PAGES + 1);
  localparam int PROD_W = BASE_W + 3;
  localparam int FULL_W = PROD_W + gasa_pkg::DIV5_MUL_W;
  localparam int NWR_W  = gasa_pkg::GLYPH_PT_W + gasa_pkg::PAGE_WIDTH_SHIFT;

  localparam logic [CW-1:0]    SIDE_C  = CW'(MAX_PAGE_SIDE);
  localparam logic [NWR_W-1:0] SIDE_N  = NWR_W'(MAX_PAGE_SIDE);
  localparam logic [PC_W-1:0]  PAGES_C = PC_W'(MAX_PAGES);

  logic              page_open_r, page_open_nxt;
  logic [PC_W-1:0]   page_count_r, page_count_nxt;
  logic [SIDE_W-1:0] page_w_r, page_w_nxt;
  logic [SIDE_W-1:0] page_h_r, page_h_nxt;
  logic [SIDE_W-1:0] wx_r, wx_nxt;
  logic [SIDE_W-1:0] wy_r, wy_nxt;
  logic [SIDE_W-1:0] rh_r, rh_nxt;

  logic [gasa_pkg::GLYPH_PT_W-1:0] fs;
  logic [CW-1:0]     w, h, pw, ph, wx, wy, rh;
  logic [CW-1:0]     wx1, wy1, rh1;
  logic              fit0, adv, fit, too_big, full;
  logic [NWR_W-1:0]  nw_raw;
  logic [CW-1:0]     nw;
  logic [11:0]       hf;
  logic [CW-1:0]     base, base_c;
  logic [BASE_W-1:0] base_n;
  logic [PROD_W-1:0] prod6;
  logic [FULL_W-1:0] nh_full;
  logic [CW-1:0]     nh;

  always_comb begin
    fs = (glyph_pt < gasa_pkg::GLYPH_PT_MIN) ? gasa_pkg::GLYPH_PT_MIN : glyph_pt;
    w  = CW'(req.glyph_width);
    h  = CW'(req.glyph_height);
    pw = CW'(page_w_r);
    ph = CW'(page_h_r);
    wx = CW'(wx_r);
    wy = CW'(wy_r);
    rh = CW'(rh_r);

    // Shelf placement in the current page; a row advance sticks once made.
    fit0 = page_open_r && (w < pw) && (h < ph);
    adv  = fit0 && ((wx + w) >= pw) && ((wy + rh + h + CW'(1)) < ph);
    wx1  = adv ? '0 : wx;
    wy1  = adv ? (wy + rh + CW'(1)) : wy;
    rh1  = adv ? '0 : rh;
    fit  = fit0 && ((wx1 + w) < pw) && ((wy1 + h) < ph);

    // New page size: width from the font size, height from 6/5 of the base.
    nw_raw  = {fs, {gasa_pkg::PAGE_WIDTH_SHIFT{1'b0}}};
    nw      = (nw_raw > SIDE_N) ? SIDE_C : CW'(nw_raw);
    hf      = (req.glyph_height > 12'(fs)) ? req.glyph_height : 12'(fs);
    base    = CW'(hf) + CW'(2);
    base_c  = (base > SIDE_C) ? SIDE_C : base;
    base_n  = BASE_W'(base_c);
    prod6   = PROD_W'({base_n, 2'b00}) + PROD_W'({base_n, 1'b0});
    nh_full = FULL_W'(prod6) * FULL_W'(gasa_pkg::DIV5_MUL);
    nh      = CW'(nh_full >> gasa_pkg::DIV5_SHIFT);

    too_big = (w >= nw) || (h >= nh);
    full    = page_count_r >= PAGES_C;

    page_open_nxt  = page_open_r;
    page_count_nxt = page_count_r;
    page_w_nxt     = page_w_r;
    page_h_nxt     = page_h_r;
    wx_nxt         = fit0 ? SIDE_W'(wx1) : wx_r;
    wy_nxt         = fit0 ? SIDE_W'(wy1) : wy_r;
    rh_nxt         = fit0 ? SIDE_W'(rh1) : rh_r;
    res            = '0;

    priority if (fit) begin
      wx_nxt         = SIDE_W'(wx1 + w + CW'(1));
      rh_nxt         = SIDE_W'((h > rh1) ? h : rh1);
      res.status     = gasa_pkg::ST_PLACED;
      res.page_index = 8'(page_count_r - PC_W'(1));
      res.pos_x      = 11'(wx1);
      res.pos_y      = 12'(wy1);
    end else if (too_big) begin
      res.status     = gasa_pkg::ST_TOO_BIG;
    end else if (full) begin
      res.status     = gasa_pkg::ST_NO_PAGES;
    end else begin
      page_open_nxt  = 1'b1;
      page_count_nxt = page_count_r + PC_W'(1);
      page_w_nxt     = SIDE_W'(nw);
      page_h_nxt     = SIDE_W'(nh);
      wx_nxt         = SIDE_W'(w + CW'(1));
      wy_nxt         = '0;
      rh_nxt         = SIDE_W'(h);
      res.status     = gasa_pkg::ST_NEW_PAGE;
      res.page_index = 8'(page_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_open_r  <= 1'b0;
      page_count_r <= '0;
      page_w_r     <= '0;
      page_h_r     <= '0;
      wx_r         <= '0;
      wy_r         <= '0;
      rh_r         <= '0;
    end else if (step) begin
      page_open_r  <= page_open_nxt;
      page_count_r <= page_count_nxt;
      page_w_r     <= page_w_nxt;
      page_h_r     <= page_h_nxt;
      wx_r         <= wx_nxt;
      wy_r         <= wy_nxt;
      rh_r         <= rh_nxt;
    end
  end

endmodule

// ===== design/gasa_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator checker
// Port-level assertions on the allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "glyph_atlas_shelf_allocator_unit_defines.svh"

module gasa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input gasa_pkg::glyph_res_t out_data
);

  logic stalled;
  logic rejected;
  logic fresh;
  logic at_origin;
  logic no_place;

  assign stalled   = out_valid && out_stall;
  assign rejected  = (out_data.status == gasa_pkg::ST_TOO_BIG) ||
                     (out_data.status == gasa_pkg::ST_NO_PAGES);
  assign fresh     = (out_data.status == gasa_pkg::ST_NEW_PAGE);
  assign at_origin = (out_data.pos_x == 11'd0) && (out_data.pos_y == 12'd0);
  assign no_place  = at_origin && (out_data.page_index == 8'd0);

  `GASA_ASSERT_NXT_ALL(a_reset_empty, !rst_n, !out_valid, "result beat right after reset")
  `GASA_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled beat changed")
  `GASA_ASSERT_IMP(a_stall_cause, in_stall, stalled, "input stalled with no stalled result")
  `GASA_ASSERT_IMP(a_reject_zero, out_valid && rejected, no_place, "rejected glyph placed")
  `GASA_ASSERT_IMP(a_new_origin, out_valid && fresh, at_origin, "new page glyph not at origin")

endmodule

bind glyph_atlas_shelf_allocator_unit gasa_checker u_gasa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
